// ===== hw/rtl/bba_pkg.sv =====
package bba_pkg;

   localparam int MAX_ORDER  = 10;
   localparam int NODE_COUNT = (2 << MAX_ORDER) - 1;
   localparam int IDX_W      = $clog2(NODE_COUNT);
   localparam int ORDER_W    = 4;
   localparam int KIND_W     = 2;
   localparam int OWNER_W    = 8;
   localparam int SIZE_W     = 14;
   localparam int ADDR_W     = 13;
   localparam int STATUS_W   = 3;

   localparam logic [KIND_W-1:0] NK_UNUSED = 2'd0;
   localparam logic [KIND_W-1:0] NK_FREE   = 2'd1;
   localparam logic [KIND_W-1:0] NK_USED   = 2'd2;
   localparam logic [KIND_W-1:0] NK_SPLIT  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_ALLOCATED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FREED     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_SIZE  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NO_OWNER  = 3'd4;

   localparam logic REQ_ALLOC = 1'b0;

   typedef struct packed {
      logic               kind_en;
      logic               owner_en;
      logic [IDX_W-1:0]   addr;
      logic [KIND_W-1:0]  kind;
      logic [OWNER_W-1:0] owner;
   } node_wr_type;

endpackage

// ===== hw/rtl/bba_node_mem.sv =====
module bba_node_mem (
   input  logic                        clock,
   input  bba_pkg::node_wr_type        wr,
   input  logic [bba_pkg::IDX_W-1:0]   rd_addr,
   output logic [bba_pkg::KIND_W-1:0]  rd_kind,
   output logic [bba_pkg::OWNER_W-1:0] rd_owner
);
   import bba_pkg::*;

   logic [KIND_W-1:0]  kind_mem  [NODE_COUNT];
   logic [OWNER_W-1:0] owner_mem [NODE_COUNT];

   always_ff @(posedge clock) begin
      if (wr.kind_en) begin
         kind_mem[wr.addr] <= wr.kind;
      end
      rd_kind <= kind_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr.owner_en) begin
         owner_mem[wr.addr] <= wr.owner;
      end
      rd_owner <= owner_mem[rd_addr];
   end

endmodule

// ===== hw/rtl/buddy_block_allocator.sv =====
// Steps: S_SIZE rounds an allocate size up; a node search is S_READ, S_EVAL, S_NEXT; a split
//   level is S_DOWN_R, S_DOWN_P; a merged level on free is S_MREAD, S_MEVAL, S_MSIB, S_MPAR.
// Throughput: one word at a time; busy stays high until the result strobe.
// Reset and every csr write rebuild the tree with a clearing pass over every node, busy high.
// The result is shown for one cycle on rsp_strobe; the receiver cannot stall it.
module buddy_block_allocator (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_kind,
   input  logic [13:0]                  req_request_size,
   input  logic [7:0]                   req_owner_id,
   output logic                         rsp_strobe,
   output logic [2:0]                   rsp_status,
   output logic [12:0]                  rsp_block_address,
   output logic [13:0]                  rsp_block_size,
   input  logic                         csr_wr_en,
   input  logic [3:0]                   csr_wr_data
);
   import bba_pkg::*;

   typedef enum logic [14:0] {
      S_CLEAR  = 15'b000000000000001,
      S_IDLE   = 15'b000000000000010,
      S_SIZE   = 15'b000000000000100,
      S_READ   = 15'b000000000001000,
      S_EVAL   = 15'b000000000010000,
      S_NEXT   = 15'b000000000100000,
      S_DOWN_R = 15'b000000001000000,
      S_DOWN_P = 15'b000000010000000,
      S_TAKE   = 15'b000000100000000,
      S_FREE   = 15'b000001000000000,
      S_MREAD  = 15'b000010000000000,
      S_MEVAL  = 15'b000100000000000,
      S_MSIB   = 15'b001000000000000,
      S_MPAR   = 15'b010000000000000,
      S_DONE   = 15'b100000000000000
   } state_type;

   state_type            state_ff, state_in;
   logic [ORDER_W-1:0]   pool_order_ff, pool_order_in;
   logic                 kind_ff, kind_in;
   logic [SIZE_W-1:0]    size_ff, size_in;
   logic [OWNER_W-1:0]   owner_ff, owner_in;
   logic [ORDER_W-1:0]   k_ff, k_in;
   logic [ORDER_W-1:0]   target_ff, target_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [ORDER_W-1:0]   depth_ff, depth_in;
   logic [IDX_W-1:0]     res_idx_ff, res_idx_in;
   logic [ORDER_W-1:0]   res_depth_ff, res_depth_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [IDX_W-1:0]     clr_ff, clr_in;
   logic                 strobe_ff, strobe_in;
   logic [STATUS_W-1:0]  out_status_ff, out_status_in;
   logic [ADDR_W-1:0]    out_addr_ff, out_addr_in;
   logic [SIZE_W-1:0]    out_size_ff, out_size_in;

   logic [ORDER_W-1:0]   order;
   logic [SIZE_W-1:0]    pool;
   node_wr_type          wr;
   logic [IDX_W-1:0]     rd_addr;
   logic [KIND_W-1:0]    rd_kind;
   logic [OWNER_W-1:0]   rd_owner;
   logic [IDX_W-1:0]     left_idx, right_idx, parent_idx, sib_idx;
   logic [ORDER_W-1:0]   shift;
   logic [IDX_W-1:0]     level_base, pos;

   bba_node_mem u_mem (
      .clock    (clock),
      .wr       (wr),
      .rd_addr  (rd_addr),
      .rd_kind  (rd_kind),
      .rd_owner (rd_owner)
   );

   assign order      = (pool_order_ff > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : pool_order_ff;
   assign pool       = SIZE_W'(8) << order;
   assign left_idx   = {idx_ff[IDX_W-2:0], 1'b1};
   assign right_idx  = {idx_ff[IDX_W-2:0], 1'b0} + IDX_W'(2);
   assign parent_idx = idx_ff[0] ? (idx_ff >> 1) : ((idx_ff >> 1) - IDX_W'(1));
   assign sib_idx    = idx_ff[0] ? (idx_ff + IDX_W'(1)) : (idx_ff - IDX_W'(1));
   assign shift      = order - res_depth_ff;
   assign level_base = (IDX_W'(1) << res_depth_ff) - IDX_W'(1);
   assign pos        = res_idx_ff - level_base;

   always_comb begin
      wr       = '0;
      wr.addr  = idx_ff;
      wr.owner = owner_ff;
      rd_addr  = idx_ff;
      case (state_ff)
         S_CLEAR: begin
            wr.kind_en = 1'b1;
            wr.addr    = clr_ff;
            wr.kind    = (clr_ff == '0) ? NK_FREE : NK_UNUSED;
         end
         S_DOWN_R: begin
            wr.kind_en = 1'b1;
            wr.addr    = right_idx;
            wr.kind    = NK_FREE;
         end
         S_DOWN_P: begin
            wr.kind_en = 1'b1;
            wr.kind    = NK_SPLIT;
         end
         S_TAKE: begin
            wr.kind_en  = 1'b1;
            wr.owner_en = 1'b1;
            wr.kind     = NK_USED;
         end
         S_FREE: begin
            wr.kind_en = 1'b1;
            wr.kind    = NK_FREE;
         end
         S_MREAD: begin
            rd_addr = sib_idx;
         end
         S_MEVAL: begin
            wr.kind_en = (rd_kind == NK_FREE);
            wr.kind    = NK_UNUSED;
         end
         S_MSIB: begin
            wr.kind_en = 1'b1;
            wr.addr    = sib_idx;
            wr.kind    = NK_UNUSED;
         end
         S_MPAR: begin
            wr.kind_en = 1'b1;
            wr.addr    = parent_idx;
            wr.kind    = NK_FREE;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      pool_order_in = pool_order_ff;
      kind_in       = kind_ff;
      size_in       = size_ff;
      owner_in      = owner_ff;
      k_in          = k_ff;
      target_in     = target_ff;
      idx_in        = idx_ff;
      depth_in      = depth_ff;
      res_idx_in    = res_idx_ff;
      res_depth_in  = res_depth_ff;
      status_in     = status_ff;
      clr_in        = clr_ff;
      strobe_in     = 1'b0;
      out_status_in = out_status_ff;
      out_addr_in   = out_addr_ff;
      out_size_in   = out_size_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_W'(NODE_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               kind_in  = req_kind;
               size_in  = req_request_size;
               owner_in = req_owner_id;
               k_in     = '0;
               idx_in   = '0;
               depth_in = '0;
               if (req_kind != REQ_ALLOC) begin
                  state_in = S_READ;
               end else if (req_request_size < SIZE_W'(8) || req_request_size > pool) begin
                  status_in = ST_BAD_SIZE;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_SIZE;
               end
            end
         end
         S_SIZE: begin
            if (k_ff < order && (SIZE_W'(8) << k_ff) < size_ff) begin
               k_in = k_ff + ORDER_W'(1);
            end else begin
               target_in = order - k_ff;
               state_in  = S_READ;
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            state_in = S_NEXT;
            if (kind_ff == REQ_ALLOC) begin
               if (rd_kind == NK_FREE) begin
                  state_in = (depth_ff == target_ff) ? S_TAKE : S_DOWN_R;
               end else if (rd_kind == NK_SPLIT && depth_ff < target_ff) begin
                  idx_in   = left_idx;
                  depth_in = depth_ff + ORDER_W'(1);
                  state_in = S_READ;
               end
            end else begin
               if (rd_kind == NK_USED && rd_owner == owner_ff) begin
                  res_idx_in   = idx_ff;
                  res_depth_in = depth_ff;
                  status_in    = ST_FREED;
                  state_in     = S_FREE;
               end else if (rd_kind == NK_SPLIT && depth_ff < order) begin
                  idx_in   = left_idx;
                  depth_in = depth_ff + ORDER_W'(1);
                  state_in = S_READ;
               end
            end
         end
         S_NEXT: begin
            if (idx_ff == '0) begin
               status_in = (kind_ff == REQ_ALLOC) ? ST_NO_SPACE : ST_NO_OWNER;
               state_in  = S_DONE;
            end else if (!idx_ff[0]) begin
               idx_in   = parent_idx;
               depth_in = depth_ff - ORDER_W'(1);
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_READ;
            end
         end
         S_DOWN_R: begin
            state_in = S_DOWN_P;
         end
         S_DOWN_P: begin
            idx_in   = left_idx;
            depth_in = depth_ff + ORDER_W'(1);
            state_in = (depth_ff + ORDER_W'(1) == target_ff) ? S_TAKE : S_DOWN_R;
         end
         S_TAKE: begin
            res_idx_in   = idx_ff;
            res_depth_in = depth_ff;
            status_in    = ST_ALLOCATED;
            state_in     = S_DONE;
         end
         S_FREE: begin
            state_in = S_MREAD;
         end
         S_MREAD: begin
            state_in = (idx_ff == '0) ? S_DONE : S_MEVAL;
         end
         S_MEVAL: begin
            state_in = (rd_kind == NK_FREE) ? S_MSIB : S_DONE;
         end
         S_MSIB: begin
            state_in = S_MPAR;
         end
         S_MPAR: begin
            idx_in   = parent_idx;
            depth_in = depth_ff - ORDER_W'(1);
            state_in = S_MREAD;
         end
         S_DONE: begin
            strobe_in     = 1'b1;
            out_status_in = status_ff;
            out_addr_in   = '0;
            out_size_in   = '0;
            if (status_ff == ST_ALLOCATED || status_ff == ST_FREED) begin
               out_addr_in = {pos[ADDR_W-4:0], 3'b000} << shift;
               out_size_in = SIZE_W'(8) << shift;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
            clr_in   = '0;
         end
      endcase
      if (csr_wr_en) begin
         pool_order_in = csr_wr_data;
         clr_in        = '0;
         state_in      = S_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         pool_order_ff <= ORDER_W'(MAX_ORDER);
         clr_ff        <= '0;
         strobe_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pool_order_ff <= pool_order_in;
         clr_ff        <= clr_in;
         strobe_ff     <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      size_ff       <= size_in;
      owner_ff      <= owner_in;
      k_ff          <= k_in;
      target_ff     <= target_in;
      idx_ff        <= idx_in;
      depth_ff      <= depth_in;
      res_idx_ff    <= res_idx_in;
      res_depth_ff  <= res_depth_in;
      status_ff     <= status_in;
      out_status_ff <= out_status_in;
      out_addr_ff   <= out_addr_in;
      out_size_ff   <= out_size_in;
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_strobe        = strobe_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_block_address = out_addr_ff;
   assign rsp_block_size    = out_size_ff;

   a_strobe_from_done: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == S_DONE))
      else $error("result strobe without finish");

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !csr_wr_en) |=> busy)
      else $error("accepted word did not raise busy");

   a_size_pow2: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == ST_ALLOCATED || rsp_status == ST_FREED))
         |-> $onehot(rsp_block_size))
      else $error("block size not a power of two");

   a_addr_aligned: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == ST_ALLOCATED || rsp_status == ST_FREED))
         |-> ((rsp_block_address & ADDR_W'(rsp_block_size - SIZE_W'(1))) == '0))
      else $error("block address not aligned to size");

endmodule
